// ----- design/slcf_pkg.sv -----
// ----------------------------------------------------------------------------
// slcf_pkg
// Shared types and constants of the sync/length/checksum frame receiver.
// ----------------------------------------------------------------------------
package slcf_pkg;

    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_LENH  = 3'd2,
        PH_LENL  = 3'd3,
        PH_TYPE  = 3'd4,
        PH_DATA  = 3'd5,
        PH_CHECK = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_PASS    = 2'd1,
        KIND_FAIL    = 2'd2,
        KIND_REJECT  = 2'd3
    } t_kind;

    localparam logic [7:0]  SYNC_FIRST    = 8'h5A;
    localparam logic [7:0]  SYNC_SECOND   = 8'h59;
    localparam logic [7:0]  LEN_HIGH_ZERO = 8'hFF;
    localparam logic [15:0] MAX_LEN_RESET = 16'd3096;
    localparam logic [15:0] HDR_CHECK_LEN = 16'd6;

    // Register index as decoded from paddr[2].
    localparam logic REG_MAX_LEN = 1'b0;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [7:0]  frame_type;
        logic [15:0] payload_length;
    } t_result;

endpackage

// ----- design/slcf_parse.sv -----
// ----------------------------------------------------------------------------
// slcf_parse
// Frame state machine: consumes one byte per request and produces at most
// one result for it.
// ----------------------------------------------------------------------------
module slcf_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_rx_byte,
    input  logic [15:0]          i_max_len,
    output logic                 o_res_valid,
    output slcf_pkg::t_result    o_result
);
    import slcf_pkg::*;

    t_phase      r_phase, n_phase;
    logic [15:0] r_total_len, n_total_len;
    logic [7:0]  r_sum, n_sum;
    logic [15:0] r_count, n_count;
    logic [7:0]  r_type, n_type;

    logic [15:0] lenl_total;
    logic [15:0] plen;
    logic [15:0] count_inc;
    logic        is_sync1;
    logic        short_frame;

    assign lenl_total  = {r_total_len[15:8], i_rx_byte};
    assign plen        = (r_total_len > HDR_CHECK_LEN) ? (r_total_len - HDR_CHECK_LEN)
                                                       : 16'd0;
    assign count_inc   = r_count + 16'd1;
    assign is_sync1    = (i_rx_byte == SYNC_FIRST);
    assign short_frame = (r_count == 16'd0) && (r_total_len <= HDR_CHECK_LEN);

    // Next state and datapath registers.
    always_comb begin
        n_phase     = r_phase;
        n_total_len = r_total_len;
        n_sum       = r_sum;
        n_count     = r_count;
        n_type      = r_type;
        case (r_phase)
            PH_SYNC2: begin
                if (i_rx_byte == SYNC_SECOND) begin
                    n_sum   = r_sum + i_rx_byte;
                    n_phase = PH_LENH;
                end else begin
                    n_phase = is_sync1 ? PH_SYNC2 : PH_SYNC1;
                    n_sum   = is_sync1 ? i_rx_byte : 8'd0;
                end
            end
            PH_LENH: begin
                n_sum       = r_sum + i_rx_byte;
                n_total_len = {((i_rx_byte == LEN_HIGH_ZERO) ? 8'd0 : i_rx_byte), 8'd0};
                n_phase     = PH_LENL;
            end
            PH_LENL: begin
                if (lenl_total > i_max_len) begin
                    n_total_len = 16'd0;
                    n_phase     = is_sync1 ? PH_SYNC2 : PH_SYNC1;
                    n_sum       = is_sync1 ? i_rx_byte : 8'd0;
                end else begin
                    n_total_len = lenl_total;
                    n_sum       = r_sum + i_rx_byte;
                    n_phase     = PH_TYPE;
                end
            end
            PH_TYPE: begin
                n_type  = i_rx_byte;
                n_sum   = r_sum + i_rx_byte;
                n_count = 16'd0;
                n_phase = PH_DATA;
            end
            PH_DATA: begin
                if (short_frame) begin
                    n_total_len = 16'd0;
                    n_phase     = is_sync1 ? PH_SYNC2 : PH_SYNC1;
                    n_sum       = is_sync1 ? i_rx_byte : 8'd0;
                end else begin
                    n_sum   = r_sum + i_rx_byte;
                    n_count = count_inc;
                    if (count_inc >= plen) begin
                        n_phase = PH_CHECK;
                    end
                end
            end
            PH_CHECK: begin
                n_count = 16'd0;
                if (r_sum == i_rx_byte) begin
                    n_phase = PH_SYNC1;
                    n_sum   = 8'd0;
                end else begin
                    n_phase = is_sync1 ? PH_SYNC2 : PH_SYNC1;
                    n_sum   = is_sync1 ? i_rx_byte : 8'd0;
                end
            end
            default: begin
                n_phase = is_sync1 ? PH_SYNC2 : PH_SYNC1;
                n_sum   = is_sync1 ? i_rx_byte : 8'd0;
            end
        endcase
    end

    // Result for the byte being accepted.
    always_comb begin
        o_res_valid = 1'b0;
        o_result    = '0;
        case (r_phase)
            PH_LENL: begin
                if (lenl_total > i_max_len) begin
                    o_res_valid   = i_accept;
                    o_result.kind = KIND_REJECT;
                end
            end
            PH_DATA: begin
                o_res_valid         = i_accept;
                o_result.frame_type = r_type;
                if (short_frame) begin
                    o_result.kind = KIND_REJECT;
                end else begin
                    o_result.kind           = KIND_PAYLOAD;
                    o_result.payload_byte   = i_rx_byte;
                    o_result.byte_index     = r_count;
                    o_result.payload_length = plen;
                end
            end
            PH_CHECK: begin
                o_res_valid             = i_accept;
                o_result.frame_type     = r_type;
                o_result.payload_length = plen;
                o_result.kind           = (r_sum == i_rx_byte) ? KIND_PASS : KIND_FAIL;
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SYNC1;
            r_total_len <= 16'd0;
            r_sum       <= 8'd0;
            r_count     <= 16'd0;
            r_type      <= 8'd0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_total_len <= n_total_len;
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_type      <= n_type;
        end
    end

endmodule

// ----- design/slcf_obuf.sv -----
// ----------------------------------------------------------------------------
// slcf_obuf
// Two-entry result buffer that separates the input stall from the output
// stall.
// ----------------------------------------------------------------------------
module slcf_obuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  slcf_pkg::t_result    i_result,
    output logic                 o_full,
    output logic                 o_valid,
    input  logic                 i_stall,
    output slcf_pkg::t_result    o_result
);
    import slcf_pkg::*;

    t_result    r_slot [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       pop;

    assign o_full   = (r_count == 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign o_result = r_slot[r_rd_ptr];
    assign pop      = o_valid && !i_stall;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_result;
        end
    end

endmodule

// ----- design/sync_length_checksum_frame_receiver_core.sv -----
// ----------------------------------------------------------------------------
// sync_length_checksum_frame_receiver_core
// Deframer for 'Z','Y' sync, 16-bit length, type, payload and additive
// checksum frames, with an APB register for the largest frame length.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  rx       in         i_rx_valid / o_rx_stall    i_rx_byte
//  res      out        o_res_valid / i_res_stall  o_kind, o_payload_byte,
//                                                 o_byte_index, o_frame_type,
//                                                 o_payload_length
//  cfg      in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One byte is taken per cycle while o_rx_stall is low; the next frame state
// and its result are combinational; the result goes into a two-entry buffer
// at the edge that accepts the byte and is offered once older entries leave.
// o_rx_stall is high while both buffer entries are occupied, which only
// happens after the output has been stalled.
// Reset is synchronous and clears the frame state and the buffer; the
// length limit returns to 3096.
// ----------------------------------------------------------------------------
module sync_length_checksum_frame_receiver_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_byte_index,
    output logic [7:0]  o_frame_type,
    output logic [15:0] o_payload_length,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import slcf_pkg::*;

    logic [15:0] r_max_len;
    logic        rx_accept;
    logic        buf_full;
    logic        res_push;
    t_result     res_in, res_out;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_LEN) ? {16'd0, r_max_len} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_LEN)) begin
            r_max_len <= pwdata[15:0];
        end
    end

    assign o_rx_stall = buf_full;
    assign rx_accept  = i_rx_valid && !buf_full;

    slcf_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (rx_accept),
        .i_rx_byte   (i_rx_byte),
        .i_max_len   (r_max_len),
        .o_res_valid (res_push),
        .o_result    (res_in)
    );

    slcf_obuf u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (res_push),
        .i_result (res_in),
        .o_full   (buf_full),
        .o_valid  (o_res_valid),
        .i_stall  (i_res_stall),
        .o_result (res_out)
    );

    assign o_kind           = res_out.kind;
    assign o_payload_byte   = res_out.payload_byte;
    assign o_byte_index     = res_out.byte_index;
    assign o_frame_type     = res_out.frame_type;
    assign o_payload_length = res_out.payload_length;

endmodule

// ----- tb/slcf_frame_checker.sv -----
// ----------------------------------------------------------------------------
// slcf_frame_checker
// Watches the byte input, the result output and the register port of the
// frame receiver. It keeps its own copy of the deframing state and of the
// length limit, predicts the results of every accepted byte, and compares
// each accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module slcf_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    input  logic        i_rx_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_payload_byte,
    input  logic [15:0] i_byte_index,
    input  logic [7:0]  i_frame_type,
    input  logic [15:0] i_payload_length,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          o_error_count,
    output int          o_pending
);

    import slcf_pkg::*;

    localparam int PRINT_CAP = 100;

    t_phase      frame_phase;
    logic [15:0] frame_total;
    logic [7:0]  frame_sum;
    logic [15:0] frame_count;
    logic [7:0]  frame_kind_byte;
    logic [15:0] length_limit;
    t_result     expected_results[$];
    int          mismatches;
    int          results_seen;

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP) begin
            $display("checker: %s", msg);
        end
        mismatches++;
    endtask

    function automatic t_result make_result(input t_kind k, input logic [7:0] pbyte,
                                            input logic [15:0] idx, input logic [7:0] ftype,
                                            input logic [15:0] plen);
        t_result r;
        r.kind           = k;
        r.payload_byte   = pbyte;
        r.byte_index     = idx;
        r.frame_type     = ftype;
        r.payload_length = plen;
        return r;
    endfunction

    // Back to hunting, with the given byte taken as a possible first sync byte.
    task automatic restart_hunt(input logic [7:0] b);
        frame_phase = PH_SYNC1;
        frame_sum   = 8'h00;
        if (b == SYNC_FIRST) begin
            frame_phase = PH_SYNC2;
            frame_sum   = b;
        end
    endtask

    task automatic predict_rx_byte(input logic [7:0] b);
        logic [15:0] plen;
        case (frame_phase)
            PH_SYNC2: begin
                if (b == SYNC_SECOND) begin
                    frame_sum   = frame_sum + b;
                    frame_phase = PH_LENH;
                end else begin
                    restart_hunt(b);
                end
            end
            PH_LENH: begin
                frame_sum   = frame_sum + b;
                frame_total = (b == LEN_HIGH_ZERO) ? 16'h0000 : {b, 8'h00};
                frame_phase = PH_LENL;
            end
            PH_LENL: begin
                frame_sum   = frame_sum + b;
                frame_total = frame_total | {8'h00, b};
                if (frame_total > length_limit) begin
                    expected_results.push_back(make_result(KIND_REJECT, 8'h00, 16'h0000,
                                                           8'h00, 16'h0000));
                    frame_total = 16'h0000;
                    restart_hunt(b);
                end else begin
                    frame_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                frame_kind_byte = b;
                frame_sum       = frame_sum + b;
                frame_count     = 16'h0000;
                frame_phase     = PH_DATA;
            end
            PH_DATA: begin
                // A frame with no payload is only noticed on the byte after its type.
                if (frame_count == 16'h0000 && frame_total <= HDR_CHECK_LEN) begin
                    expected_results.push_back(make_result(KIND_REJECT, 8'h00, 16'h0000,
                                                           frame_kind_byte, 16'h0000));
                    frame_total = 16'h0000;
                    restart_hunt(b);
                end else begin
                    plen      = frame_total - HDR_CHECK_LEN;
                    frame_sum = frame_sum + b;
                    expected_results.push_back(make_result(KIND_PAYLOAD, b, frame_count,
                                                           frame_kind_byte, plen));
                    frame_count = frame_count + 16'd1;
                    if (frame_count >= plen) begin
                        frame_phase = PH_CHECK;
                    end
                end
            end
            PH_CHECK: begin
                plen = (frame_total > HDR_CHECK_LEN) ? frame_total - HDR_CHECK_LEN : 16'h0000;
                frame_count = 16'h0000;
                if (frame_sum == b) begin
                    expected_results.push_back(make_result(KIND_PASS, 8'h00, 16'h0000,
                                                           frame_kind_byte, plen));
                    frame_phase = PH_SYNC1;
                    frame_sum   = 8'h00;
                end else begin
                    expected_results.push_back(make_result(KIND_FAIL, 8'h00, 16'h0000,
                                                           frame_kind_byte, plen));
                    restart_hunt(b);
                end
            end
            default: begin
                restart_hunt(b);
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            frame_phase     = PH_SYNC1;
            frame_total     = 16'h0000;
            frame_sum       = 8'h00;
            frame_count     = 16'h0000;
            frame_kind_byte = 8'h00;
            length_limit    = MAX_LEN_RESET;
            expected_results.delete();
        end else begin
            if (psel && penable && pready && paddr[2] == REG_MAX_LEN) begin
                if (pwrite) begin
                    length_limit = pwdata[15:0];
                end else if (prdata !== {16'h0000, length_limit}) begin
                    report_mismatch($sformatf("length limit read %0h, expected %0h",
                                              prdata, length_limit));
                end
            end

            // Compare before predicting: a byte's result never leaves on its own edge.
            if (i_res_valid && !i_res_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                end else begin
                    want = expected_results.pop_front();
                    if (i_kind !== want.kind)
                        report_mismatch($sformatf("result %0d: kind %0d, expected %0d",
                                                  results_seen, i_kind, want.kind));
                    if (i_payload_byte !== want.payload_byte)
                        report_mismatch($sformatf("result %0d: payload byte %0h, expected %0h",
                                                  results_seen, i_payload_byte,
                                                  want.payload_byte));
                    if (i_byte_index !== want.byte_index)
                        report_mismatch($sformatf("result %0d: byte index %0d, expected %0d",
                                                  results_seen, i_byte_index,
                                                  want.byte_index));
                    if (i_frame_type !== want.frame_type)
                        report_mismatch($sformatf("result %0d: frame type %0h, expected %0h",
                                                  results_seen, i_frame_type,
                                                  want.frame_type));
                    if (i_payload_length !== want.payload_length)
                        report_mismatch($sformatf("result %0d: payload length %0d, expected %0d",
                                                  results_seen, i_payload_length,
                                                  want.payload_length));
                end
                results_seen++;
            end

            if (i_rx_valid && !i_rx_stall) begin
                predict_rx_byte(i_rx_byte);
            end
        end
        o_pending     <= expected_results.size();
        o_error_count <= mismatches;
    end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the sync/length/checksum frame receiver. A short directed
// sequence covers sync slips, the 0xFF length high byte, length and empty
// payload rejects and checksum pass and fail; then random frames, broken
// syncs and noise run under several length limits, with bursty requests
// and a receiver that stalls in changing patterns. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    import slcf_pkg::*;

    localparam int          RUN_LIMIT      = 3_200_000;
    localparam int          IDLE_CYCLES    = 8;
    localparam int          TAIL_GOOD      = 0;
    localparam int          TAIL_BAD       = 1;
    localparam int          TAIL_AFTER_LEN = 2;
    localparam int          TAIL_AFTER_TYPE = 3;
    localparam int          STALL_NONE     = 0;
    localparam int          STALL_RANDOM   = 1;
    localparam int          STALL_RUNS     = 2;
    localparam int          STALL_TOGGLE   = 3;
    localparam logic [2:0]  ADDR_MAX_LEN   = 3'd0;
    localparam logic [2:0]  ADDR_UNUSED    = 3'd4;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        rx_valid       = 1'b0;
    logic        rx_stall;
    logic [7:0]  rx_byte        = 8'h00;
    logic        res_valid;
    logic        res_stall      = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [7:0]  frame_type;
    logic [15:0] payload_length;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [2:0]  paddr          = 3'd0;
    logic [31:0] pwdata         = 32'h0;
    logic [31:0] prdata;
    logic        pready;
    int          error_count;
    int          pending;

    bit          rx_on          = 1'b0;
    int          burst_left     = 0;
    int          items_sent     = 0;
    int          frames_sent    = 0;
    int          limits_used    = 0;
    int          cur_max        = MAX_LEN_RESET;

    int          stall_mode      = STALL_NONE;
    int          stall_mode_left = 0;
    int          stall_run_left  = 0;
    logic        stall_level     = 1'b0;
    logic        next_res_stall;

    sync_length_checksum_frame_receiver_core u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_rx_valid       (rx_valid),
        .o_rx_stall       (rx_stall),
        .i_rx_byte        (rx_byte),
        .o_res_valid      (res_valid),
        .i_res_stall      (res_stall),
        .o_kind           (kind),
        .o_payload_byte   (payload_byte),
        .o_byte_index     (byte_index),
        .o_frame_type     (frame_type),
        .o_payload_length (payload_length),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    slcf_frame_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_rx_valid       (rx_valid),
        .i_rx_stall       (rx_stall),
        .i_rx_byte        (rx_byte),
        .i_res_valid      (res_valid),
        .i_res_stall      (res_stall),
        .i_kind           (kind),
        .i_payload_byte   (payload_byte),
        .i_byte_index     (byte_index),
        .i_frame_type     (frame_type),
        .i_payload_length (payload_length),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_error_count    (error_count),
        .o_pending        (pending)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // The result side stalls in modes that change every so often.
    always @(posedge clk) begin
        if (stall_mode_left == 0) begin
            stall_mode      = $urandom_range(STALL_NONE, STALL_TOGGLE);
            stall_mode_left = $urandom_range(16, 160);
        end else begin
            stall_mode_left--;
        end
        case (stall_mode)
            STALL_NONE:   next_res_stall = 1'b0;
            STALL_RANDOM: next_res_stall = ($urandom_range(0, 99) < 35);
            STALL_RUNS: begin
                if (stall_run_left == 0) begin
                    stall_level    = ~stall_level;
                    stall_run_left = $urandom_range(1, 16);
                end else begin
                    stall_run_left--;
                end
                next_res_stall = stall_level;
            end
            default:      next_res_stall = ~res_stall;
        endcase
        res_stall <= next_res_stall;
    end

    // Offers one byte and returns at the edge that accepts it. Between bursts
    // the request may be dropped for a random gap.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        rx_byte  <= b;
        rx_valid <= 1'b1;
        rx_on = 1'b1;
        do @(posedge clk); while (rx_stall);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
            if (gap > 0) begin
                rx_valid <= 1'b0;
                rx_on = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_frame(input logic [15:0] total, input bit high_as_ff,
                              input logic [7:0] ftype, input int n_payload,
                              input int tail);
        logic [7:0] hi;
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] chk;
        hi  = high_as_ff ? LEN_HIGH_ZERO : total[15:8];
        sum = SYNC_FIRST + SYNC_SECOND + hi + total[7:0];
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(hi);
        send_byte(total[7:0]);
        if (tail != TAIL_AFTER_LEN) begin
            send_byte(ftype);
            sum = sum + ftype;
            if (tail != TAIL_AFTER_TYPE) begin
                repeat (n_payload) begin
                    b = $urandom;
                    send_byte(b);
                    sum = sum + b;
                end
                chk = sum;
                if (tail == TAIL_BAD) begin
                    chk = sum + $urandom_range(1, 255);
                    // A wrong checksum that is itself a sync byte starts the next hunt.
                    if ($urandom_range(0, 3) == 0 && sum != SYNC_FIRST) begin
                        chk = SYNC_FIRST;
                    end
                end
                send_byte(chk);
            end
        end
        frames_sent++;
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] addr, input logic [15:0] value);
        logic [31:0] data;
        data       = $urandom;
        data[15:0] = value;
        apb_access(1'b1, addr, data);
        apb_access(1'b0, ADDR_MAX_LEN, 32'h0);
    endtask

    // Drops the request and waits until every predicted result is out.
    task automatic wait_idle();
        if (rx_on) begin
            rx_valid <= 1'b0;
            rx_on = 1'b0;
        end
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        #(RUN_LIMIT);
        $display("testbench: done, errors");
        $finish;
    end

    initial begin
        int          sel;
        int          plen;
        int          hi_len;
        int          budget_end;
        logic [15:0] frame_len;
        logic [7:0]  b;
        logic [15:0] limit_values [7];
        int          phase_items [7];

        limit_values[0] = 16'hFFFF;
        limit_values[1] = 16'd0;
        limit_values[2] = HDR_CHECK_LEN;
        limit_values[3] = HDR_CHECK_LEN + 16'd1;
        limit_values[4] = $urandom_range(8, 300);
        limit_values[5] = $urandom_range(301, 5000);
        limit_values[6] = MAX_LEN_RESET;
        phase_items     = '{200, 40, 50, 60, 200, 150, 200};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, at the reset length limit.
        // Empty-payload header; the next frame's first byte rejects it and restarts.
        send_frame(16'd6, 1'b0, 8'hA5, 0, TAIL_AFTER_TYPE);
        send_frame(16'd7, 1'b0, 8'h00, 1, TAIL_GOOD);
        // Repeated first sync byte, length high byte 0xFF, bad checksum.
        send_byte(SYNC_FIRST);
        send_frame(16'd8, 1'b1, 8'hFF, 2, TAIL_BAD);
        // One past the reset limit.
        send_frame(MAX_LEN_RESET + 16'd1, 1'b0, 8'h00, 0, TAIL_AFTER_LEN);

        wait_idle();
        cfg_write(ADDR_UNUSED, 16'h0005);

        for (int ph = 0; ph < 7; ph++) begin
            wait_idle();
            cfg_write(ADDR_MAX_LEN, limit_values[ph]);
            cur_max = limit_values[ph];
            limits_used++;
            budget_end = items_sent + phase_items[ph];
            while (items_sent < budget_end) begin
                sel = $urandom_range(0, 99);
                if (sel < 65) begin
                    plen      = ($urandom_range(0, 6) == 0) ? $urandom_range(17, 200)
                                                            : $urandom_range(1, 16);
                    frame_len = plen + 6;
                    send_frame(frame_len, frame_len < 256 && $urandom_range(0, 1) == 1,
                               $urandom, plen, (sel < 55) ? TAIL_GOOD : TAIL_BAD);
                end else if (sel < 73 && cur_max < 16'hFEFF) begin
                    hi_len = cur_max + 600;
                    if (hi_len > 16'hFEFF) begin
                        hi_len = 16'hFEFF;
                    end
                    frame_len = $urandom_range(cur_max + 1, hi_len);
                    send_frame(frame_len, frame_len < 256 && $urandom_range(0, 1) == 1,
                               8'h00, 0, TAIL_AFTER_LEN);
                end else if (sel < 80) begin
                    frame_len = $urandom_range(0, HDR_CHECK_LEN);
                    send_frame(frame_len, $urandom_range(0, 1) == 1, $urandom, 0,
                               TAIL_AFTER_TYPE);
                end else if (sel < 88) begin
                    b = $urandom;
                    if (b == SYNC_SECOND) begin
                        b = 8'h00;
                    end
                    send_byte(SYNC_FIRST);
                    send_byte(b);
                end else begin
                    repeat ($urandom_range(1, 8)) begin
                        send_byte($urandom);
                    end
                end
            end
        end

        wait_idle();
        repeat (16) @(posedge clk);
        $display("testbench: %0d bytes sent, %0d frame headers, %0d length limits",
                 items_sent, frames_sent, limits_used + 1);
        $display("testbench: bursty requests against four result stall patterns");
        if (error_count == 0 && pending == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
